// File: rtl/sphp_pkg.sv
// ----------------------------------------------------------------------------
// sphp_pkg: shared types and constants of the secure packet header parser
// Header layout sizes, result kinds and the word carried by the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

package sphp_pkg;

   // Auth tag length in bytes at the end of a secured datagram
   localparam int unsigned TAG_BYTES   = 16;

   // Header layout sizes
   localparam int unsigned LEGACY_SIZE = 14;
   localparam int unsigned FLAGS_SIZE  = 16;
   localparam int unsigned SEC_SIZE    = 12;
   localparam int unsigned NONCE_BYTES = 8;

   // Byte on which the fixed header is complete and the layout is decided
   localparam int unsigned DECIDE_POS  = 13;

   // Result queue between parser and output stage
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // Channel widths
   localparam int unsigned REQ_DATA_W  = 24;
   localparam int unsigned RSP_DATA_W  = 232;
   localparam int unsigned RSP_USER_W  = 2;

   // Result kind
   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_TAG     = 2'd1,
      KIND_RECORD  = 2'd2,
      KIND_REJECT  = 2'd3
   } kind_type;

   // Layout decision of the current datagram
   typedef struct packed {
      logic rejected;
      logic secured;
      logic flags_form;
   } mode_type;

   // Decoded header fields
   typedef struct packed {
      logic [31:0] key_id;
      logic [63:0] nonce;
      logic [15:0] flag_bits;
      logic [15:0] sequence_res;
      logic [31:0] sender_id;
      logic [31:0] channel_id;
      logic [15:0] header_length;
      logic [7:0]  packet_type;
      logic [7:0]  version;
   } hdr_type;

   // One queued result
   typedef struct packed {
      kind_type   kind;
      logic [7:0] out_byte;
      logic       last;
      hdr_type    hdr;
   } entry_type;

endpackage

`default_nettype wire

// File: rtl/sphp_front.sv
// ----------------------------------------------------------------------------
// sphp_front: byte parser
// Tracks the byte position, collects big-endian header fields, decides the
// layout on the last fixed-header byte and classifies every byte.
// ----------------------------------------------------------------------------
`default_nettype none

module sphp_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output      logic                in_ready,
   input  wire logic [7:0]          in_byte,
   input  wire logic [15:0]         in_length,
   output      logic                push_valid,
   output      sphp_pkg::entry_type push_entry,
   input  wire logic                push_ready
);

   logic [15:0] pos_ff, pos_in;
   logic [7:0]  version_ff, version_in;
   logic [7:0]  ptype_ff, ptype_in;
   logic [15:0] hlen_ff, hlen_in;
   logic [31:0] channel_ff, channel_in;
   logic [31:0] sender_ff, sender_in;
   logic [15:0] seq_ff, seq_in;
   logic [15:0] flags_ff, flags_in;
   logic [63:0] nonce_ff, nonce_in;
   logic [31:0] key_ff, key_in;
   sphp_pkg::mode_type mode_ff, mode_now, mode_new;

   logic        accept;
   logic [16:0] pos_x, len_x;
   logic        final_byte;
   logic [16:0] fix_new;
   logic [15:0] fsz, hdr_end;
   logic        past_decide, is_record, is_payload, is_tag;

   assign accept   = in_valid & push_ready;
   assign in_ready = push_ready;
   assign pos_x    = {1'b0, pos_ff};
   assign len_x    = {1'b0, in_length};

   // Final byte of the datagram
   assign final_byte = (pos_x + 17'd1) >= len_x;

   // Layout decision from the complete fixed header
   always_comb begin
      mode_new.flags_form = (hlen_ff == 16'(sphp_pkg::FLAGS_SIZE)) ||
                            (hlen_ff == 16'(sphp_pkg::FLAGS_SIZE + sphp_pkg::SEC_SIZE));
      fix_new = mode_new.flags_form ? 17'(sphp_pkg::FLAGS_SIZE)
                                    : 17'(sphp_pkg::LEGACY_SIZE);
      mode_new.secured = ({1'b0, hlen_ff} >= fix_new + 17'(sphp_pkg::SEC_SIZE)) &&
                         (len_x >= fix_new + 17'(sphp_pkg::SEC_SIZE + sphp_pkg::TAG_BYTES));
      mode_new.rejected = !mode_new.secured && ({1'b0, hlen_ff} != fix_new);
   end

   assign mode_now = (pos_ff == 16'(sphp_pkg::DECIDE_POS)) ? mode_new : mode_ff;
   assign fsz      = mode_now.flags_form ? 16'(sphp_pkg::FLAGS_SIZE)
                                         : 16'(sphp_pkg::LEGACY_SIZE);
   assign hdr_end  = fsz - 16'd1 + (mode_now.secured ? 16'(sphp_pkg::SEC_SIZE) : 16'd0);

   // Field capture
   always_comb begin
      version_in = version_ff;
      ptype_in   = ptype_ff;
      hlen_in    = hlen_ff;
      channel_in = channel_ff;
      sender_in  = sender_ff;
      seq_in     = seq_ff;
      flags_in   = flags_ff;
      nonce_in   = nonce_ff;
      key_in     = key_ff;
      priority if (pos_ff == 16'd0) begin
         version_in = in_byte;
      end else if (pos_ff == 16'd1) begin
         ptype_in = in_byte;
      end else if (pos_ff < 16'd4) begin
         hlen_in = {hlen_ff[7:0], in_byte};
      end else if (pos_ff < 16'd8) begin
         channel_in = {channel_ff[23:0], in_byte};
      end else if (pos_ff < 16'd12) begin
         sender_in = {sender_ff[23:0], in_byte};
      end else if (pos_ff < 16'd14) begin
         seq_in = {seq_ff[7:0], in_byte};
      end else begin
      end
      if (mode_now.flags_form && (pos_ff == 16'd14 || pos_ff == 16'd15)) begin
         flags_in = {flags_ff[7:0], in_byte};
      end
      if (mode_now.secured && pos_ff >= fsz &&
          pos_ff < fsz + 16'(sphp_pkg::SEC_SIZE)) begin
         if (pos_ff < fsz + 16'(sphp_pkg::NONCE_BYTES)) begin
            nonce_in = {nonce_ff[55:0], in_byte};
         end else begin
            key_in = {key_ff[23:0], in_byte};
         end
      end
   end

   // Classification
   assign past_decide = pos_ff >= 16'(sphp_pkg::DECIDE_POS);
   assign is_record   = !mode_now.rejected && past_decide && (pos_ff == hdr_end);
   assign is_payload  = !mode_now.rejected && past_decide && (pos_ff > hdr_end);
   assign is_tag      = mode_now.secured && (pos_x + 17'(sphp_pkg::TAG_BYTES) >= len_x);

   // Result word
   always_comb begin
      push_entry          = '0;
      push_entry.kind     = sphp_pkg::KIND_REJECT;
      push_entry.last     = final_byte;
      push_entry.hdr.version       = version_in;
      push_entry.hdr.packet_type   = ptype_in;
      push_entry.hdr.header_length = hlen_in;
      push_entry.hdr.channel_id    = channel_in;
      push_entry.hdr.sender_id     = sender_in;
      push_entry.hdr.sequence_res  = seq_in;
      push_entry.hdr.flag_bits     = flags_in;
      push_entry.hdr.nonce         = nonce_in;
      push_entry.hdr.key_id        = key_in;
      priority if (is_record) begin
         push_entry.kind = sphp_pkg::KIND_RECORD;
      end else if (is_payload) begin
         push_entry.kind     = is_tag ? sphp_pkg::KIND_TAG : sphp_pkg::KIND_PAYLOAD;
         push_entry.out_byte = in_byte;
      end else begin
         push_entry.kind = sphp_pkg::KIND_REJECT;
      end
   end

   assign push_valid = accept & (is_record | is_payload | final_byte);

   // State update; a final byte returns everything to the idle state
   always_ff @(posedge clock) begin
      if (reset || (accept && final_byte)) begin
         pos_ff     <= '0;
         mode_ff    <= '0;
         version_ff <= '0;
         ptype_ff   <= '0;
         hlen_ff    <= '0;
         channel_ff <= '0;
         sender_ff  <= '0;
         seq_ff     <= '0;
         flags_ff   <= '0;
         nonce_ff   <= '0;
         key_ff     <= '0;
      end else if (accept) begin
         pos_ff     <= pos_in;
         mode_ff    <= mode_now;
         version_ff <= version_in;
         ptype_ff   <= ptype_in;
         hlen_ff    <= hlen_in;
         channel_ff <= channel_in;
         sender_ff  <= sender_in;
         seq_ff     <= seq_in;
         flags_ff   <= flags_in;
         nonce_ff   <= nonce_in;
         key_ff     <= key_in;
      end
   end

   assign pos_in = pos_ff + 16'd1;

endmodule

`default_nettype wire

// File: rtl/sphp_queue.sv
// ----------------------------------------------------------------------------
// sphp_queue: result queue
// Short FIFO between the parser and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sphp_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   input  wire sphp_pkg::entry_type push_entry,
   output      logic                push_ready,
   output      logic                pop_valid,
   output      sphp_pkg::entry_type pop_entry,
   input  wire logic                pop
);

   sphp_pkg::entry_type mem [sphp_pkg::QUEUE_DEPTH];

   logic [sphp_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [sphp_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [sphp_pkg::QUEUE_CW-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign push_ready = count_ff < sphp_pkg::QUEUE_CW'(sphp_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_entry  = mem[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop & pop_valid;

   // Pointer and fill-count next values
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == sphp_pkg::QUEUE_AW'(sphp_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == sphp_pkg::QUEUE_AW'(sphp_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + sphp_pkg::QUEUE_CW'(do_push) - sphp_pkg::QUEUE_CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// File: rtl/sphp_back.sv
// ----------------------------------------------------------------------------
// sphp_back: output stage
// Pulls results from the queue into the output register and packs the word;
// header fields are zero on everything but the header record.
// ----------------------------------------------------------------------------
`default_nettype none

module sphp_back (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                pop_valid,
   input  wire sphp_pkg::entry_type                 pop_entry,
   output      logic                                pop,
   output      logic                                out_valid,
   input  wire logic                                out_ready,
   output      logic [sphp_pkg::RSP_DATA_W-1:0]     out_data,
   output      logic [sphp_pkg::RSP_USER_W-1:0]     out_user,
   output      logic                                out_last
);

   logic                            valid_ff, valid_in;
   logic [sphp_pkg::RSP_DATA_W-1:0] data_ff, data_in;
   logic [sphp_pkg::RSP_USER_W-1:0] user_ff, user_in;
   logic                            last_ff, last_in;
   sphp_pkg::hdr_type               hdr;

   // Load whenever the register is empty or being drained
   assign pop = pop_valid & (!valid_ff | out_ready);

   assign hdr = (pop_entry.kind == sphp_pkg::KIND_RECORD) ? pop_entry.hdr : '0;

   // Next output word
   always_comb begin
      valid_in = valid_ff & !out_ready;
      data_in  = data_ff;
      user_in  = user_ff;
      last_in  = last_ff;
      if (pop) begin
         valid_in = 1'b1;
         data_in  = {hdr.key_id, hdr.nonce, hdr.flag_bits, hdr.sequence_res,
                     hdr.sender_id, hdr.channel_id, hdr.header_length,
                     hdr.packet_type, hdr.version, pop_entry.out_byte};
         user_in  = pop_entry.kind;
         last_in  = pop_entry.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      user_ff <= user_in;
      last_ff <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign out_user  = user_ff;
   assign out_last  = last_ff;

endmodule

`default_nettype wire

// File: rtl/secure_packet_header_parser.sv
// ----------------------------------------------------------------------------
// secure_packet_header_parser: byte-serial datagram header parser
// Splits a datagram into one header record, payload bytes and auth tag bytes,
// or a single reject result for a malformed datagram.
//
//   channel | dir | payload                              | side info
//   --------+-----+--------------------------------------+------------------
//   req_    | in  | data_byte, datagram_length           | -
//   rsp_    | out | out_byte, header fields              | tuser kind, tlast
//
// One byte is accepted per cycle while the queue has room; the parser classifies
// it in the cycle it is taken, and results reach rsp_ through the queue write,
// then the output register. A two-entry queue decouples parser and output, so
// a stall on rsp_ backs up into req_tready only once the queue is full.
// Reset is synchronous and returns the parser to the start of a datagram.
// ----------------------------------------------------------------------------
`default_nettype none

module secure_packet_header_parser (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   // [7:0] data_byte, [23:8] datagram_length
   input  wire logic [sphp_pkg::REQ_DATA_W-1:0]     req_tdata,
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [7:0] out_byte, [15:8] version, [23:16] packet_type,
   // [39:24] header_length, [71:40] channel_id, [103:72] sender_id,
   // [119:104] sequence_res, [135:120] flag_bits, [199:136] nonce,
   // [231:200] key_id
   output      logic [sphp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // [1:0] kind
   output      logic [sphp_pkg::RSP_USER_W-1:0]     rsp_tuser,
   output      logic                                rsp_tlast
);

   logic                push_valid, push_ready;
   sphp_pkg::entry_type push_entry;
   logic                pop_valid, pop;
   sphp_pkg::entry_type pop_entry;

   // Parser
   sphp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata[7:0]),
      .in_length  (req_tdata[23:8]),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   // Result queue
   sphp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop        (pop)
   );

   // Output stage
   sphp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_entry (pop_entry),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata),
      .out_user  (rsp_tuser),
      .out_last  (rsp_tlast)
   );

endmodule

`default_nettype wire

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for secure_packet_header_parser
// A short table of directed bytes runs first: one-byte and zero-length
// datagrams, a length that drops in the middle of a datagram, and a minimal
// legacy header with one payload byte. Random datagrams follow: well-formed
// legacy, flags and secured layouts, mismatched header lengths, truncated
// headers, noise and datagrams whose length moves from byte to byte.
// Both stream sides idle at random. Every result word is checked field by
// field against its directed row or the byte-level parser model kept inside the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // Expectation source of one directed row
   typedef enum logic [1:0] {
      ROW_MODEL = 2'd0,   // checked against the parser model
      ROW_NONE  = 2'd1,   // no word expected
      ROW_WORD  = 2'd2    // word given in the row
   } row_exp_type;

   typedef struct packed {
      logic [7:0]         data_byte;
      logic [15:0]        dgram_len;
      row_exp_type        row_exp;
      sphp_pkg::kind_type kind;
      logic [7:0]         out_byte;
      logic               last;
   } stim_row_type;

   localparam int DIR_ROWS = 19;
   localparam stim_row_type DIR_TABLE [DIR_ROWS] = '{
      // one-byte datagram and zero length: final at once, rejected
      '{8'hFF, 16'd1,     ROW_WORD,  sphp_pkg::KIND_REJECT,  8'h00, 1'b1},
      '{8'h00, 16'd0,     ROW_WORD,  sphp_pkg::KIND_REJECT,  8'h00, 1'b1},
      // length drops from max to 2 on the second byte
      '{8'h5A, 16'hFFFF,  ROW_NONE,  sphp_pkg::KIND_PAYLOAD, 8'h00, 1'b0},
      '{8'hA5, 16'd2,     ROW_WORD,  sphp_pkg::KIND_REJECT,  8'h00, 1'b1},
      // legacy header (length 14), then one payload byte
      '{8'hFF, 16'd15,    ROW_NONE,  sphp_pkg::KIND_PAYLOAD, 8'h00, 1'b0},
      '{8'h00, 16'd15,    ROW_NONE,  sphp_pkg::KIND_PAYLOAD, 8'h00, 1'b0},
      '{8'h00, 16'd15,    ROW_NONE,  sphp_pkg::KIND_PAYLOAD, 8'h00, 1'b0},
      '{8'h0E, 16'd15,    ROW_NONE,  sphp_pkg::KIND_PAYLOAD, 8'h00, 1'b0},
      '{8'hFF, 16'd15,    ROW_NONE,  sphp_pkg::KIND_PAYLOAD, 8'h00, 1'b0},
      '{8'hFF, 16'd15,    ROW_NONE,  sphp_pkg::KIND_PAYLOAD, 8'h00, 1'b0},
      '{8'hFF, 16'd15,    ROW_NONE,  sphp_pkg::KIND_PAYLOAD, 8'h00, 1'b0},
      '{8'hFF, 16'd15,    ROW_NONE,  sphp_pkg::KIND_PAYLOAD, 8'h00, 1'b0},
      '{8'h00, 16'd15,    ROW_NONE,  sphp_pkg::KIND_PAYLOAD, 8'h00, 1'b0},
      '{8'h00, 16'd15,    ROW_NONE,  sphp_pkg::KIND_PAYLOAD, 8'h00, 1'b0},
      '{8'h00, 16'd15,    ROW_NONE,  sphp_pkg::KIND_PAYLOAD, 8'h00, 1'b0},
      '{8'h00, 16'd15,    ROW_NONE,  sphp_pkg::KIND_PAYLOAD, 8'h00, 1'b0},
      '{8'hFF, 16'd15,    ROW_NONE,  sphp_pkg::KIND_PAYLOAD, 8'h00, 1'b0},
      '{8'hFF, 16'd15,    ROW_MODEL, sphp_pkg::KIND_RECORD,  8'h00, 1'b0},
      '{8'hA5, 16'd15,    ROW_WORD,  sphp_pkg::KIND_PAYLOAD, 8'hA5, 1'b1}
   };

   localparam int RANDOM_BYTES = 1950;

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [sphp_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [sphp_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [sphp_pkg::RSP_USER_W-1:0] rsp_tuser;
   logic                            rsp_tlast;

   // Parser model state
   logic [15:0]        byte_pos   = '0;
   sphp_pkg::hdr_type  hdr_acc    = '0;
   sphp_pkg::mode_type layout_acc = '0;

   sphp_pkg::entry_type expected_words [$];
   logic [7:0]          dg_bytes [$];
   logic [15:0]         dg_lens [$];
   int                  mismatches = 0;
   int                  bytes_sent = 0;
   bit                  tx_burst   = 0;
   bit                  rx_burst   = 0;

   secure_packet_header_parser u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Parse one accepted byte; returns the word it causes, if any
   function automatic void parse_byte(input logic [7:0] b, input logic [15:0] len,
                                      output bit has_word,
                                      output sphp_pkg::entry_type word);
      int unsigned        p;
      int unsigned        fsz;
      int unsigned        hdr_end;
      int unsigned        hl;
      int unsigned        len_w;
      bit                 is_final;
      sphp_pkg::mode_type m;
      p        = 32'(byte_pos);
      len_w    = 32'(len);
      is_final = (p + 1) >= len_w;
      has_word = 1'b0;
      word     = '0;

      // big-endian fixed header collection
      if (p == 0)
         hdr_acc.version = b;
      else if (p == 1)
         hdr_acc.packet_type = b;
      else if (p < 4)
         hdr_acc.header_length = {hdr_acc.header_length[7:0], b};
      else if (p < 8)
         hdr_acc.channel_id = {hdr_acc.channel_id[23:0], b};
      else if (p < 12)
         hdr_acc.sender_id = {hdr_acc.sender_id[23:0], b};
      else if (p < 14)
         hdr_acc.sequence_res = {hdr_acc.sequence_res[7:0], b};

      // layout decided once the fixed header is in
      if (p == sphp_pkg::DECIDE_POS) begin
         hl           = 32'(hdr_acc.header_length);
         m            = '0;
         m.flags_form = (hl == sphp_pkg::FLAGS_SIZE) ||
                        (hl == sphp_pkg::FLAGS_SIZE + sphp_pkg::SEC_SIZE);
         fsz          = m.flags_form ? sphp_pkg::FLAGS_SIZE : sphp_pkg::LEGACY_SIZE;
         if (hl >= fsz + sphp_pkg::SEC_SIZE &&
             len_w >= fsz + sphp_pkg::SEC_SIZE + sphp_pkg::TAG_BYTES)
            m.secured = 1'b1;
         else if (hl != fsz)
            m.rejected = 1'b1;
         layout_acc = m;
      end

      fsz = layout_acc.flags_form ? sphp_pkg::FLAGS_SIZE : sphp_pkg::LEGACY_SIZE;
      if (layout_acc.flags_form &&
          (p == sphp_pkg::LEGACY_SIZE || p == sphp_pkg::LEGACY_SIZE + 1))
         hdr_acc.flag_bits = {hdr_acc.flag_bits[7:0], b};
      if (layout_acc.secured && p >= fsz && p < fsz + sphp_pkg::SEC_SIZE) begin
         if (p < fsz + sphp_pkg::NONCE_BYTES)
            hdr_acc.nonce = {hdr_acc.nonce[55:0], b};
         else
            hdr_acc.key_id = {hdr_acc.key_id[23:0], b};
      end
      hdr_end = fsz - 1 + (layout_acc.secured ? sphp_pkg::SEC_SIZE : 0);

      if (!layout_acc.rejected && p >= sphp_pkg::DECIDE_POS && p == hdr_end) begin
         has_word  = 1'b1;
         word.kind = sphp_pkg::KIND_RECORD;
         word.hdr  = hdr_acc;
         word.last = is_final;
      end else if (!layout_acc.rejected && p >= sphp_pkg::DECIDE_POS && p > hdr_end) begin
         has_word      = 1'b1;
         word.kind     = (layout_acc.secured && p + sphp_pkg::TAG_BYTES >= len_w)
                         ? sphp_pkg::KIND_TAG : sphp_pkg::KIND_PAYLOAD;
         word.out_byte = b;
         word.last     = is_final;
      end else if (is_final) begin
         has_word  = 1'b1;
         word.kind = sphp_pkg::KIND_REJECT;
         word.last = 1'b1;
      end

      if (is_final) begin
         byte_pos   = '0;
         hdr_acc    = '0;
         layout_acc = '0;
      end else begin
         byte_pos = 16'(p + 1);
      end
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Send one byte after a random gap; model it once the word is taken
   task automatic send_byte(input logic [7:0] b, input logic [15:0] len,
                            output bit has_word, output sphp_pkg::entry_type word);
      int unsigned gap;
      if ($urandom_range(0, 99) == 0)
         tx_burst = !tx_burst;
      gap = tx_burst ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= sphp_pkg::REQ_DATA_W'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {len, b};
      do @(posedge clock); while (req_tready !== 1'b1);
      bytes_sent++;
      parse_byte(b, len, has_word, word);
   endtask

   task automatic put_field(input logic [63:0] v, input int n);
      for (int i = n - 1; i >= 0; i--)
         dg_bytes.push_back(v[8*i +: 8]);
   endtask

   // One random datagram into dg_bytes / dg_lens
   task automatic build_datagram();
      int unsigned pick;
      int unsigned form;
      int unsigned n_pay;
      int unsigned hdr_bytes;
      int unsigned keep;
      logic [15:0] hlen;
      dg_bytes.delete();
      dg_lens.delete();
      pick = $urandom_range(0, 99);

      if (pick >= 90) begin
         // noise
         repeat ($urandom_range(1, 40)) dg_bytes.push_back(8'($urandom));
      end else begin
         // form bit 0: flags word, bit 1: security header
         form = $urandom_range(0, 3);
         case (form)
            0: hlen = 16'(sphp_pkg::LEGACY_SIZE);
            1: hlen = 16'(sphp_pkg::FLAGS_SIZE);
            3: hlen = 16'(sphp_pkg::FLAGS_SIZE + sphp_pkg::SEC_SIZE);
            default: begin
               if ($urandom_range(0, 1))
                  hlen = 16'(sphp_pkg::LEGACY_SIZE + sphp_pkg::SEC_SIZE +
                             $urandom_range(0, 1));
               else
                  hlen = 16'($urandom_range(sphp_pkg::FLAGS_SIZE + sphp_pkg::SEC_SIZE + 1,
                                            65535));
            end
         endcase
         n_pay = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 100)
                                              : $urandom_range(0, 12);
         // header length that matches no layout; too short to be secured
         if (pick >= 62 && pick < 74) begin
            form = 0;
            hlen = 16'($urandom);
            if (hlen == 16'(sphp_pkg::LEGACY_SIZE) || hlen == 16'(sphp_pkg::FLAGS_SIZE) ||
                hlen == 16'(sphp_pkg::FLAGS_SIZE + sphp_pkg::SEC_SIZE))
               hlen = hlen ^ 16'h8000;
            n_pay = $urandom_range(0, 27);
         end
         put_field(64'($urandom), 1);
         put_field(64'($urandom), 1);
         put_field(64'(hlen), 2);
         put_field(64'($urandom), 4);
         put_field(64'($urandom), 4);
         put_field(64'($urandom), 2);
         if (form[0])
            put_field(64'($urandom), 2);
         if (form[1]) begin
            put_field({$urandom, $urandom}, 8);
            put_field(64'($urandom), 4);
         end
         hdr_bytes = dg_bytes.size();
         repeat (n_pay) dg_bytes.push_back(8'($urandom));
         if (form[1])
            repeat (sphp_pkg::TAG_BYTES) dg_bytes.push_back(8'($urandom));
         // truncated inside the header
         if (pick >= 74 && pick < 84) begin
            keep = $urandom_range(1, hdr_bytes - 1);
            while (dg_bytes.size() > keep) void'(dg_bytes.pop_back());
         end
      end

      // length moving per byte for noise and some well-formed datagrams
      for (int i = 0; i < dg_bytes.size(); i++) begin
         if (pick < 84)
            dg_lens.push_back(16'(dg_bytes.size()));
         else if (i == dg_bytes.size() - 1)
            dg_lens.push_back(16'($urandom_range(0, i + 1)));
         else
            dg_lens.push_back(16'($urandom_range(i + 2, 65535)));
      end
   endtask

   // Stimulus
   initial begin : stimulus
      bit                  has_word;
      sphp_pkg::entry_type word;
      sphp_pkg::entry_type row_word;
      int                  n_dgrams;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      n_dgrams   = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int r = 0; r < DIR_ROWS; r++) begin
         send_byte(DIR_TABLE[r].data_byte, DIR_TABLE[r].dgram_len, has_word, word);
         case (DIR_TABLE[r].row_exp)
            ROW_MODEL: begin
               if (has_word)
                  expected_words.push_back(word);
            end
            ROW_WORD: begin
               row_word          = '0;
               row_word.kind     = DIR_TABLE[r].kind;
               row_word.out_byte = DIR_TABLE[r].out_byte;
               row_word.last     = DIR_TABLE[r].last;
               expected_words.push_back(row_word);
            end
            default: ;
         endcase
      end

      // random datagrams
      while (bytes_sent < DIR_ROWS + RANDOM_BYTES) begin
         build_datagram();
         for (int i = 0; i < dg_bytes.size(); i++) begin
            send_byte(dg_bytes[i], dg_lens[i], has_word, word);
            if (has_word)
               expected_words.push_back(word);
         end
         n_dgrams++;
         // now and then let the result side drain completely
         if (n_dgrams % 16 == 0 && expected_words.size() != 0) begin
            req_tvalid <= 1'b0;
            while (expected_words.size() != 0) @(posedge clock);
         end
      end

      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // Result side: random stall before each word, with stall-free stretches
   initial begin : rsp_stall
      int unsigned stall;
      rsp_tready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 63) == 0)
            rx_burst = !rx_burst;
         stall = rx_burst ? 0 : $urandom_range(0, 14);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
      end
   end

   // Compare each taken word with the oldest expectation
   always @(posedge clock) begin : rsp_check
      sphp_pkg::entry_type got;
      sphp_pkg::entry_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind     = sphp_pkg::kind_type'(rsp_tuser);
         got.out_byte = rsp_tdata[7:0];
         got.hdr      = rsp_tdata[sphp_pkg::RSP_DATA_W-1:8];
         got.last     = rsp_tlast;
         if (expected_words.size() == 0) begin
            $display("%0t ns: unexpected word, expected none, actual kind %0d byte %h",
                     $time, got.kind, got.out_byte);
            mismatches++;
         end else begin
            want = expected_words.pop_front();
            check_field("kind", want.kind, got.kind);
            check_field("out_byte", want.out_byte, got.out_byte);
            check_field("last", want.last, got.last);
            check_field("version", want.hdr.version, got.hdr.version);
            check_field("packet_type", want.hdr.packet_type, got.hdr.packet_type);
            check_field("header_length", want.hdr.header_length, got.hdr.header_length);
            check_field("channel_id", want.hdr.channel_id, got.hdr.channel_id);
            check_field("sender_id", want.hdr.sender_id, got.hdr.sender_id);
            check_field("sequence_res", want.hdr.sequence_res, got.hdr.sequence_res);
            check_field("flag_bits", want.hdr.flag_bits, got.hdr.flag_bits);
            check_field("nonce", want.hdr.nonce, got.hdr.nonce);
            check_field("key_id", want.hdr.key_id, got.hdr.key_id);
         end
      end
   end

   // Run limit
   initial begin : watchdog
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire
